### design/tcw_pkg.sv
// Shared types, constants and command/status structs of the text console writer.
package tcw_pkg;

    localparam int ACT_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int POS_W     = 11;
    localparam int HOME_W    = 11;
    localparam int CELL_W    = ATTR_W + CHAR_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 11;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam int ROWS_DEF    = 25;
    localparam int COLUMNS_DEF = 80;

    localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [ATTR_W-1:0] RESET_COLOR = 8'd7;

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_CELL  = 1'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT    = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    // Commands from the controller to the datapath; at most one memory command a cycle.
    typedef struct packed {
        logic capture;
        logic ptr_clr;
        logic fill_wr;
        logic fill_init;
        logic copy_step;
        logic put_wr;
        logic nl_step;
        logic scroll_cur;
        logic set_scrolled;
        logic del_rd;
        logic del_wr;
        logic rd_req;
        logic home_load;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    is_newline;
        logic    at_end;
        logic    at_zero;
        logic    ptr_at_last;
        logic    ptr_at_end;
        logic    out_free;
    } t_dp_stat;

endpackage

### design/tcw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/tcw_datapath.sv
// Datapath of the text console writer: cell memory, cursor, configuration and result register.
module tcw_datapath #(
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tcw_pkg::t_dp_cmd               i_cmd,
    output tcw_pkg::t_dp_stat              o_stat,
    input  logic [tcw_pkg::ACT_W-1:0]      i_act,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char,
    input  logic [tcw_pkg::IDX_W-1:0]      i_idx,
    input  logic                           i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcw_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int XW    = (CW > HOME_W) ? CW : HOME_W;

    localparam logic [CW-1:0] CELLS_C  = CW'(CELLS);
    localparam logic [CW-1:0] COLS_C   = CW'(COLUMNS);
    localparam logic [CW-1:0] COLSM1_C = CW'(COLUMNS - 1);
    localparam logic [CW-1:0] SCROLL_C = CW'(CELLS - COLUMNS);
    localparam logic [XW-1:0] CELLS_X  = XW'(CELLS);
    localparam logic [AW-1:0] LAST_A   = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] END_A    = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);

    logic [ATTR_W-1:0] r_color;
    logic [HOME_W-1:0] r_home;

    t_action           r_act;
    logic [CHAR_W-1:0] r_char;
    logic              r_idx_ok;
    logic [AW-1:0]     r_idx_a;
    logic              r_scrolled;

    logic [CW-1:0]     r_cursor;
    logic [CW-1:0]     r_col;

    logic [AW-1:0]     r_ptr;
    logic              r_pend;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic [XW-1:0]     home_ext;
    logic [CW-1:0]     home_sat;
    logic [XW-1:0]     idx_ext;
    logic [CW-1:0]     cur_m1;
    logic [XW-1:0]     cur_ext;
    logic [CELL_W-1:0] blank;
    logic              rd_ok;
    logic [CHAR_W-1:0] res_char;
    logic [ATTR_W-1:0] res_attr;
    logic              copy_more;

    assign home_ext  = XW'(r_home);
    assign home_sat  = (home_ext > CELLS_X) ? CELLS_C : home_ext[CW-1:0];
    assign idx_ext   = XW'(i_idx);
    assign cur_m1    = r_cursor - CW'(1);
    assign cur_ext   = XW'(r_cursor);
    assign blank     = {(i_cmd.fill_init ? RESET_COLOR : r_color), CH_SPACE};
    assign copy_more = (r_ptr < LAST_A);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= RESET_COLOR;
            r_home  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_TEXT_COLOR) begin
                r_color <= i_cfg_data[ATTR_W-1:0];
            end else begin
                r_home <= i_cfg_data[HOME_W-1:0];
            end
        end
    end

    // Captured word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act    <= t_action'(i_act);
            r_char   <= i_char;
            r_idx_ok <= (idx_ext < CELLS_X);
            r_idx_a  <= idx_ext[AW-1:0];
        end
        if (i_cmd.capture) begin
            r_scrolled <= 1'b0;
        end else if (i_cmd.set_scrolled) begin
            r_scrolled <= 1'b1;
        end
    end

    // Memory port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        priority if (i_cmd.fill_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_ptr;
            ram_wdata = blank;
        end else if (i_cmd.copy_step) begin
            // Read one row ahead while writing the word read in the previous cycle.
            ram_re    = copy_more;
            ram_raddr = r_ptr + COLS_A;
            ram_we    = r_pend;
            ram_waddr = r_ptr - AW'(1);
            ram_wdata = ram_rdata;
        end else if (i_cmd.put_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_cursor[AW-1:0];
            ram_wdata = {r_color, r_char};
        end else if (i_cmd.del_rd) begin
            ram_re    = 1'b1;
            ram_raddr = cur_m1[AW-1:0];
        end else if (i_cmd.del_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_cursor[AW-1:0];
            ram_wdata = {ram_rdata[CELL_W-1:CHAR_W], CH_SPACE};
        end else if (i_cmd.rd_req) begin
            ram_re    = r_idx_ok;
            ram_raddr = r_idx_a;
        end else begin
            ram_we = 1'b0;
        end
    end

    // Sweep pointer for reset fill, clear and scroll.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.fill_wr) begin
                r_ptr <= r_ptr + AW'(1);
            end else if (i_cmd.copy_step && copy_more) begin
                r_ptr <= r_ptr + AW'(1);
            end
            if (i_cmd.ptr_clr) begin
                r_pend <= 1'b0;
            end else if (i_cmd.copy_step) begin
                r_pend <= copy_more;
            end
        end
    end

    // Cursor, kept both as a cell index and as a column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_col    <= '0;
        end else if (i_cmd.home_load) begin
            // The column is reduced by one row per cycle while the clear runs.
            r_cursor <= home_sat;
            r_col    <= home_sat;
        end else if (i_cmd.scroll_cur) begin
            r_cursor <= SCROLL_C;
            r_col    <= '0;
        end else if (i_cmd.nl_step) begin
            r_cursor <= r_cursor - r_col + COLS_C;
            r_col    <= '0;
        end else if (i_cmd.put_wr) begin
            r_cursor <= r_cursor + CW'(1);
            if (r_col == COLSM1_C) begin
                r_col <= '0;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end else if (i_cmd.del_rd) begin
            r_cursor <= cur_m1;
            if (r_col == '0) begin
                r_col <= COLSM1_C;
            end else begin
                r_col <= r_col - CW'(1);
            end
        end else if (r_col >= COLS_C) begin
            r_col <= r_col - COLS_C;
        end
    end

    // Result register.
    assign rd_ok    = (r_act == ACT_READ) && r_idx_ok;
    assign res_char = rd_ok ? ram_rdata[CHAR_W-1:0] : '0;
    assign res_attr = rd_ok ? ram_rdata[CELL_W-1:CHAR_W] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= M_TDATA_W'({r_scrolled, cur_ext[POS_W-1:0], res_attr, res_char});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign o_stat.action      = r_act;
    assign o_stat.is_newline  = (r_char == CH_NEWLINE);
    assign o_stat.at_end      = (r_cursor == CELLS_C);
    assign o_stat.at_zero     = (r_cursor == '0);
    assign o_stat.ptr_at_last = (r_ptr == LAST_A);
    assign o_stat.ptr_at_end  = (r_ptr == END_A);
    assign o_stat.out_free    = !r_out_valid || i_m_tready;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

### design/tcw_ctrl.sv
// Controller state machine of the text console writer.
module tcw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  tcw_pkg::t_dp_stat  i_stat,
    output tcw_pkg::t_dp_cmd   o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [10:0] {
        S_INIT     = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_DISPATCH = 11'b000_0000_0100,
        S_CLEAR    = 11'b000_0000_1000,
        S_SC_COPY  = 11'b000_0001_0000,
        S_SC_BLANK = 11'b000_0010_0000,
        S_PUT      = 11'b000_0100_0000,
        S_DEL_RD   = 11'b000_1000_0000,
        S_DEL_WR   = 11'b001_0000_0000,
        S_RD       = 11'b010_0000_0000,
        S_FINISH   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                // Power-up fill of every cell with a space in the reset colour.
                o_cmd.fill_wr   = 1'b1;
                o_cmd.fill_init = 1'b1;
                if (i_stat.ptr_at_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.action)
                    ACT_PUT: begin
                        if (i_stat.at_end) begin
                            o_cmd.ptr_clr      = 1'b1;
                            o_cmd.set_scrolled = 1'b1;
                            o_cmd.scroll_cur   = !i_stat.is_newline;
                            n_state            = S_SC_COPY;
                        end else if (i_stat.is_newline) begin
                            o_cmd.nl_step = 1'b1;
                            n_state       = S_FINISH;
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    ACT_DELETE: begin
                        n_state = i_stat.at_zero ? S_FINISH : S_DEL_RD;
                    end
                    ACT_CLEAR: begin
                        o_cmd.ptr_clr   = 1'b1;
                        o_cmd.home_load = 1'b1;
                        n_state         = S_CLEAR;
                    end
                    ACT_READ: begin
                        n_state = S_RD;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_CLEAR: begin
                o_cmd.fill_wr = 1'b1;
                if (i_stat.ptr_at_end) begin
                    n_state = S_FINISH;
                end
            end
            S_SC_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_stat.ptr_at_last) begin
                    n_state = S_SC_BLANK;
                end
            end
            S_SC_BLANK: begin
                o_cmd.fill_wr = 1'b1;
                if (i_stat.ptr_at_end) begin
                    n_state = i_stat.is_newline ? S_FINISH : S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put_wr = 1'b1;
                n_state      = S_FINISH;
            end
            S_DEL_RD: begin
                o_cmd.del_rd = 1'b1;
                n_state      = S_DEL_WR;
            end
            S_DEL_WR: begin
                o_cmd.del_wr = 1'b1;
                n_state      = S_FINISH;
            end
            S_RD: begin
                o_cmd.rd_req = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

### design/text_console_writer_core.sv
// Text console writer: a ROWS x COLUMNS character grid with cursor, delete, clear and scroll.
// Each accepted word passes a dispatch state, then the states of its action, then a finish state
// that loads the result register; a scroll copies every row up by one row and blanks the last row
// before the put. One word is in flight at a time: no word is taken before the last result is loaded.
// The reset fill, clear and scroll sweep the grid through the single write port of the cell memory.
// After reset a clearing pass fills the grid before any word is taken.
module text_console_writer_core #(
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [7:0] character, [18:8] cell_index, [23:19] zero
    input  logic [tcw_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [1:0] action
    input  logic [tcw_pkg::ACT_W-1:0]      i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] read_character, [15:8] read_attribute, [26:16] cursor_position,
    // [27] scrolled, [31:28] zero
    output logic [tcw_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                           i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcw_pkg::CFG_W-1:0]      i_cfg_data
);
    import tcw_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcw_datapath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_act       (i_s_tuser),
        .i_char      (i_s_tdata[CHAR_W-1:0]),
        .i_idx       (i_s_tdata[CHAR_W+IDX_W-1:CHAR_W]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
